FILE: src/emc_pkg.sv
// shared widths, register codes and item types of the epipolar motion classifier
`default_nettype none
package emc_pkg;
	// fixed field and register widths
	localparam int FIELD_W   = 16;
	localparam int CFG_W     = 64;
	localparam int HALF_W    = 32;
	localparam int LIM_W     = 12;
	localparam int LSQ_W     = 2 * LIM_W;
	localparam int REG_IDX_W = 3;

	// datapath sizing
	localparam int COORD_W    = 16;
	localparam int COEF_W     = 32;
	localparam int COORD_FRAC = 4;
	localparam int NCOEF      = 9;
	localparam int NSTAGE     = 9;

	localparam int PW   = COEF_W + COORD_W + 1;   // coefficient times coordinate
	localparam int LW   = PW + 2;                 // line terms A, B, C
	localparam int MW   = LW - 1;                 // |A|, |B|
	localparam int NW   = LW + COORD_W + 2;       // numerator
	localparam int NMW  = NW - 1;                 // |num|
	localparam int MLO  = MW / 2;
	localparam int MHI  = MW - MLO;
	localparam int SQW  = 2 * MW;                 // A^2
	localparam int SW   = SQW + 1;                // A^2 + B^2
	localparam int NLO  = NMW / 2;
	localparam int NHI  = NMW - NLO;
	localparam int LHW  = 2 * NMW;                // num^2
	localparam int SP   = (SW + 2) / 3;           // slice of A^2 + B^2 per multiplier
	localparam int SPAD = 3 * SP;
	localparam int RPW  = SP + LSQ_W;
	localparam int RHW  = SW + LSQ_W;             // limit^2 * (A^2 + B^2)
	localparam int CMPW = (LHW > RHW) ? LHW : RHW;

	localparam logic [LIM_W-1:0] DIST_LIMIT_RESET = LIM_W'(32);

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_F00_F01    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_F02_F10    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_F11_F12    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_F20_F21    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_F22        = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DIST_LIMIT = 3'd5;

	// matrix entry positions
	localparam int F00 = 0;
	localparam int F01 = 1;
	localparam int F02 = 2;
	localparam int F10 = 3;
	localparam int F11 = 4;
	localparam int F12 = 5;
	localparam int F20 = 6;
	localparam int F21 = 7;
	localparam int F22 = 8;

	// point classes
	localparam logic [1:0] CLS_DROP   = 2'd0;
	localparam logic [1:0] CLS_STATIC = 2'd1;
	localparam logic [1:0] CLS_MOVING = 2'd2;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic [COORD_W-1:0] cur_x;
		logic [COORD_W-1:0] cur_y;
		logic               track_ok;
	} side_t;
endpackage
`default_nettype wire

FILE: src/emc_line.sv
// epipolar line terms A, B, C from the matrix and the previous point (stages 1-2)
`default_nettype none
module emc_line (
	input  wire logic                             clk,
	input  wire logic [1:0]                       stage_en,
	input  wire emc_pkg::coef_t                   coef [emc_pkg::NCOEF],
	input  wire logic [emc_pkg::COORD_W-1:0]      px,
	input  wire logic [emc_pkg::COORD_W-1:0]      py,
	output logic signed [emc_pkg::LW-1:0]         a_s2,
	output logic signed [emc_pkg::LW-1:0]         b_s2,
	output logic signed [emc_pkg::LW-1:0]         c_s2
);
	localparam int PW = emc_pkg::PW;
	localparam int LW = emc_pkg::LW;

	logic signed [emc_pkg::COORD_W:0] sx;
	logic signed [emc_pkg::COORD_W:0] sy;
	logic signed [PW-1:0] pa0_s1, pa1_s1, pb0_s1, pb1_s1, pc0_s1, pc1_s1;
	emc_pkg::coef_t fa2_s1, fb2_s1, fc2_s1;

	assign sx = $signed({1'b0, px});
	assign sy = $signed({1'b0, py});

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			pa0_s1 <= PW'(coef[emc_pkg::F00] * sx);
			pa1_s1 <= PW'(coef[emc_pkg::F01] * sy);
			pb0_s1 <= PW'(coef[emc_pkg::F10] * sx);
			pb1_s1 <= PW'(coef[emc_pkg::F11] * sy);
			pc0_s1 <= PW'(coef[emc_pkg::F20] * sx);
			pc1_s1 <= PW'(coef[emc_pkg::F21] * sy);
			fa2_s1 <= coef[emc_pkg::F02];
			fb2_s1 <= coef[emc_pkg::F12];
			fc2_s1 <= coef[emc_pkg::F22];
		end
	end

	// constant column is scaled to the Q.4 of the coordinates
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			a_s2 <= LW'(pa0_s1) + LW'(pa1_s1) + (LW'(fa2_s1) <<< emc_pkg::COORD_FRAC);
			b_s2 <= LW'(pb0_s1) + LW'(pb1_s1) + (LW'(fb2_s1) <<< emc_pkg::COORD_FRAC);
			c_s2 <= LW'(pc0_s1) + LW'(pc1_s1) + (LW'(fc2_s1) <<< emc_pkg::COORD_FRAC);
		end
	end
endmodule
`default_nettype wire

FILE: src/emc_square.sv
// numerator, line norm and split squares (stages 3-6)
`default_nettype none
module emc_square (
	input  wire logic                             clk,
	input  wire logic [3:0]                       stage_en,
	input  wire logic signed [emc_pkg::LW-1:0]    a,
	input  wire logic signed [emc_pkg::LW-1:0]    b,
	input  wire logic signed [emc_pkg::LW-1:0]    c,
	input  wire logic [emc_pkg::COORD_W-1:0]      cx,
	input  wire logic [emc_pkg::COORD_W-1:0]      cy,
	output logic [2*emc_pkg::NHI-1:0]             nhh_s6,
	output logic [emc_pkg::NHI+emc_pkg::NLO-1:0]  nhl_s6,
	output logic [2*emc_pkg::NLO-1:0]             nll_s6,
	output logic [emc_pkg::SW-1:0]                s_s6
);
	localparam int LW  = emc_pkg::LW;
	localparam int MW  = emc_pkg::MW;
	localparam int NW  = emc_pkg::NW;
	localparam int NMW = emc_pkg::NMW;
	localparam int MLO = emc_pkg::MLO;
	localparam int MHI = emc_pkg::MHI;
	localparam int NLO = emc_pkg::NLO;
	localparam int NHI = emc_pkg::NHI;
	localparam int SQW = emc_pkg::SQW;
	localparam int SW  = emc_pkg::SW;
	localparam int HHW = 2 * MHI;
	localparam int HLW = MHI + MLO;
	localparam int LLW = 2 * MLO;
	localparam int NHHW = 2 * NHI;
	localparam int NHLW = NHI + NLO;
	localparam int NLLW = 2 * NLO;

	logic signed [emc_pkg::COORD_W:0] sx;
	logic signed [emc_pkg::COORD_W:0] sy;

	logic signed [NW-1:0] ta_s3, tb_s3, tc_s3;
	logic [MW-1:0]        maga_s3, magb_s3;
	logic signed [NW-1:0] num_s4;
	logic [HHW-1:0]       ahh_s4, bhh_s4;
	logic [HLW-1:0]       ahl_s4, bhl_s4;
	logic [LLW-1:0]       all_s4, bll_s4;
	logic [NMW-1:0]       nmag_s5;
	logic [SQW-1:0]       asq_s5, bsq_s5;

	assign sx = $signed({1'b0, cx});
	assign sy = $signed({1'b0, cy});

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			ta_s3   <= NW'(a * sx);
			tb_s3   <= NW'(b * sy);
			tc_s3   <= NW'(c) <<< emc_pkg::COORD_FRAC;
			maga_s3 <= a[LW-1] ? MW'(-a) : MW'(a);
			magb_s3 <= b[LW-1] ? MW'(-b) : MW'(b);
		end
	end

	// numerator sum, and squares of |A| and |B| as hi/lo partial products
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			num_s4 <= ta_s3 + tb_s3 + tc_s3;
			ahh_s4 <= HHW'(maga_s3[MW-1:MLO] * maga_s3[MW-1:MLO]);
			ahl_s4 <= HLW'(maga_s3[MW-1:MLO] * maga_s3[MLO-1:0]);
			all_s4 <= LLW'(maga_s3[MLO-1:0] * maga_s3[MLO-1:0]);
			bhh_s4 <= HHW'(magb_s3[MW-1:MLO] * magb_s3[MW-1:MLO]);
			bhl_s4 <= HLW'(magb_s3[MW-1:MLO] * magb_s3[MLO-1:0]);
			bll_s4 <= LLW'(magb_s3[MLO-1:0] * magb_s3[MLO-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			nmag_s5 <= num_s4[NW-1] ? NMW'(-num_s4) : NMW'(num_s4);
			asq_s5  <= (SQW'(ahh_s4) << (2 * MLO)) + (SQW'(ahl_s4) << (MLO + 1))
				+ SQW'(all_s4);
			bsq_s5  <= (SQW'(bhh_s4) << (2 * MLO)) + (SQW'(bhl_s4) << (MLO + 1))
				+ SQW'(bll_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			nhh_s6 <= NHHW'(nmag_s5[NMW-1:NLO] * nmag_s5[NMW-1:NLO]);
			nhl_s6 <= NHLW'(nmag_s5[NMW-1:NLO] * nmag_s5[NLO-1:0]);
			nll_s6 <= NLLW'(nmag_s5[NLO-1:0] * nmag_s5[NLO-1:0]);
			s_s6   <= SW'(asq_s5) + SW'(bsq_s5);
		end
	end
endmodule
`default_nettype wire

FILE: src/emc_test.sv
// squared distance test against the limit and class register (stages 7-9)
`default_nettype none
module emc_test (
	input  wire logic                             clk,
	input  wire logic [2:0]                       stage_en,
	input  wire logic [2*emc_pkg::NHI-1:0]        nhh,
	input  wire logic [emc_pkg::NHI+emc_pkg::NLO-1:0] nhl,
	input  wire logic [2*emc_pkg::NLO-1:0]        nll,
	input  wire logic [emc_pkg::SW-1:0]           s,
	input  wire logic [emc_pkg::LSQ_W-1:0]        lim_sq,
	input  wire logic                             track_ok,
	output logic [1:0]                            cls_s9
);
	localparam int LHW  = emc_pkg::LHW;
	localparam int RHW  = emc_pkg::RHW;
	localparam int RPW  = emc_pkg::RPW;
	localparam int SP   = emc_pkg::SP;
	localparam int SPAD = emc_pkg::SPAD;
	localparam int NLO  = emc_pkg::NLO;
	localparam int CMPW = emc_pkg::CMPW;

	logic [SPAD-1:0] spad;
	logic [LHW-1:0]  lhs_s7, lhs_s8;
	logic [RPW-1:0]  r0_s7, r1_s7, r2_s7;
	logic [RHW-1:0]  rhs_s8;

	assign spad = SPAD'(s);

	// numerator square assembled, and limit^2 times the norm, one slice of the norm per multiplier
	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			lhs_s7 <= (LHW'(nhh) << (2 * NLO)) + (LHW'(nhl) << (NLO + 1)) + LHW'(nll);
			r0_s7  <= RPW'(spad[SP-1:0] * lim_sq);
			r1_s7  <= RPW'(spad[2*SP-1:SP] * lim_sq);
			r2_s7  <= RPW'(spad[SPAD-1:2*SP] * lim_sq);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			lhs_s8 <= lhs_s7;
			rhs_s8 <= RHW'(r0_s7) + (RHW'(r1_s7) << SP) + (RHW'(r2_s7) << (2 * SP));
		end
	end

	// degenerate line falls out naturally: rhs is zero, so only num = 0 is static
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			if (!track_ok)
				cls_s9 <= emc_pkg::CLS_DROP;
			else if (CMPW'(lhs_s8) <= CMPW'(rhs_s8))
				cls_s9 <= emc_pkg::CLS_STATIC;
			else
				cls_s9 <= emc_pkg::CLS_MOVING;
		end
	end
endmodule
`default_nettype wire

FILE: src/epipolar_motion_classifier.sv
// top level: matrix registers, pipeline control and the three datapath sections
// throughput: one item per cycle through the nine-stage multiplier pipeline while out_stall is low
// a stalled output holds its result while empty stages upstream keep filling
// reset clears all valid bits, zeroes the matrix and sets the limit to 2.0 pixels
// no clearing pass: the block takes items from the first cycle after reset
`default_nettype none
module epipolar_motion_classifier (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [emc_pkg::REG_IDX_W-1:0]   cfg_addr,
	input  wire logic [emc_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [emc_pkg::FIELD_W-1:0]     prev_x,
	input  wire logic [emc_pkg::FIELD_W-1:0]     prev_y,
	input  wire logic [emc_pkg::FIELD_W-1:0]     cur_x,
	input  wire logic [emc_pkg::FIELD_W-1:0]     cur_y,
	input  wire logic                            track_ok,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [1:0]                           point_class,
	output logic [emc_pkg::FIELD_W-1:0]          out_x,
	output logic [emc_pkg::FIELD_W-1:0]          out_y
);
	localparam int NSTAGE  = emc_pkg::NSTAGE;
	localparam int COEF_W  = emc_pkg::COEF_W;
	localparam int COORD_W = emc_pkg::COORD_W;
	localparam int HALF_W  = emc_pkg::HALF_W;
	localparam int LIM_W   = emc_pkg::LIM_W;
	localparam int LSQ_W   = emc_pkg::LSQ_W;
	localparam int FIELD_W = emc_pkg::FIELD_W;

	emc_pkg::coef_t          coef_q [emc_pkg::NCOEF];
	logic [LIM_W-1:0]        dist_limit_q;
	logic [LSQ_W-1:0]        lim_sq_q;

	logic [NSTAGE:1]         vld_s;
	logic [NSTAGE:1]         stage_en;
	emc_pkg::side_t          side_s [1:NSTAGE];

	logic signed [emc_pkg::LW-1:0]                 a_s2, b_s2, c_s2;
	logic [2*emc_pkg::NHI-1:0]                     nhh_s6;
	logic [emc_pkg::NHI+emc_pkg::NLO-1:0]          nhl_s6;
	logic [2*emc_pkg::NLO-1:0]                     nll_s6;
	logic [emc_pkg::SW-1:0]                        s_s6;
	logic [1:0]                                    cls_s9;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < emc_pkg::NCOEF; i++)
				coef_q[i] <= '0;
			dist_limit_q <= emc_pkg::DIST_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				emc_pkg::REG_F00_F01: begin
					coef_q[emc_pkg::F00] <= cfg_data[HALF_W +: COEF_W];
					coef_q[emc_pkg::F01] <= cfg_data[0 +: COEF_W];
				end
				emc_pkg::REG_F02_F10: begin
					coef_q[emc_pkg::F02] <= cfg_data[HALF_W +: COEF_W];
					coef_q[emc_pkg::F10] <= cfg_data[0 +: COEF_W];
				end
				emc_pkg::REG_F11_F12: begin
					coef_q[emc_pkg::F11] <= cfg_data[HALF_W +: COEF_W];
					coef_q[emc_pkg::F12] <= cfg_data[0 +: COEF_W];
				end
				emc_pkg::REG_F20_F21: begin
					coef_q[emc_pkg::F20] <= cfg_data[HALF_W +: COEF_W];
					coef_q[emc_pkg::F21] <= cfg_data[0 +: COEF_W];
				end
				emc_pkg::REG_F22: begin
					coef_q[emc_pkg::F22] <= cfg_data[0 +: COEF_W];
				end
				emc_pkg::REG_DIST_LIMIT: begin
					dist_limit_q <= cfg_data[LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// squared limit, registered from the distance limit register and used in stage 7
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lim_sq_q <= LSQ_W'(emc_pkg::DIST_LIMIT_RESET * emc_pkg::DIST_LIMIT_RESET);
		else
			lim_sq_q <= LSQ_W'(dist_limit_q * dist_limit_q);
	end

	// a stage moves when it is empty or the stage after it moves; the last moves when the output is not stalled
	always_comb begin
		stage_en[NSTAGE] = !vld_s[NSTAGE] || !out_stall;
		for (int k = NSTAGE - 1; k >= 1; k--)
			stage_en[k] = !vld_s[k] || stage_en[k + 1];
	end

	assign in_stall = !stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (stage_en[1])
				vld_s[1] <= in_valid;
			for (int k = 2; k <= NSTAGE; k++)
				if (stage_en[k])
					vld_s[k] <= vld_s[k - 1];
		end
	end

	// current point and track flag ride along with the item
	always_ff @(posedge clk) begin
		if (stage_en[1])
			side_s[1] <= '{cur_x: cur_x[COORD_W-1:0], cur_y: cur_y[COORD_W-1:0],
				track_ok: track_ok};
		for (int k = 2; k <= NSTAGE; k++)
			if (stage_en[k])
				side_s[k] <= side_s[k - 1];
	end

	emc_line u_line (
		.clk      (clk),
		.stage_en (stage_en[2:1]),
		.coef     (coef_q),
		.px       (prev_x[COORD_W-1:0]),
		.py       (prev_y[COORD_W-1:0]),
		.a_s2     (a_s2),
		.b_s2     (b_s2),
		.c_s2     (c_s2)
	);

	emc_square u_square (
		.clk      (clk),
		.stage_en (stage_en[6:3]),
		.a        (a_s2),
		.b        (b_s2),
		.c        (c_s2),
		.cx       (side_s[2].cur_x),
		.cy       (side_s[2].cur_y),
		.nhh_s6   (nhh_s6),
		.nhl_s6   (nhl_s6),
		.nll_s6   (nll_s6),
		.s_s6     (s_s6)
	);

	emc_test u_test (
		.clk      (clk),
		.stage_en (stage_en[9:7]),
		.nhh      (nhh_s6),
		.nhl      (nhl_s6),
		.nll      (nll_s6),
		.s        (s_s6),
		.lim_sq   (lim_sq_q),
		.track_ok (side_s[8].track_ok),
		.cls_s9   (cls_s9)
	);

	assign out_valid   = vld_s[NSTAGE];
	assign point_class = cls_s9;
	assign out_x       = FIELD_W'(side_s[NSTAGE].cur_x);
	assign out_y       = FIELD_W'(side_s[NSTAGE].cur_y);

`ifndef SYNTHESIS
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_s && out_stall) |-> in_stall)
		else $error("full pipeline with stalled output still takes items");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	a_drop_class: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !side_s[NSTAGE].track_ok) |-> point_class == emc_pkg::CLS_DROP)
		else $error("invalid track not reported as dropped");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[4] && !stage_en[4]) |=> vld_s[4])
		else $error("held item lost in middle stage");
`endif
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// self-checking testbench for the epipolar motion classifier: predicts and checks each point
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import emc_pkg::*;

	localparam int LATENCY          = 9;
	localparam int QUIET_LIMIT      = 4000;
	localparam int PHASES           = 8;
	localparam int ITEMS_PER_PHASE  = 200;
	localparam int SHOW_LIMIT       = 10;
	// indexes past the last register, writes there must be ignored
	localparam logic [REG_IDX_W-1:0] NO_REG_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] NO_REG_B = 3'd7;

	typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	typedef struct {
		logic [FIELD_W-1:0] px;
		logic [FIELD_W-1:0] py;
		logic [FIELD_W-1:0] cx;
		logic [FIELD_W-1:0] cy;
		logic               ok;
	} pair_t;

	typedef struct {
		logic [1:0]         cls;
		logic [FIELD_W-1:0] x;
		logic [FIELD_W-1:0] y;
	} point_t;

	class motion_ledger;
		longint coef[NCOEF];
		logic [LIM_W-1:0] limit;
		point_t expected_points[$];
		int errors;
		int shown;

		function new();
			foreach (coef[i]) coef[i] = 0;
			limit = DIST_LIMIT_RESET;
			errors = 0;
			shown = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_F00_F01: begin
					coef[F00] = longint'(coef_t'(data[63:32]));
					coef[F01] = longint'(coef_t'(data[31:0]));
				end
				REG_F02_F10: begin
					coef[F02] = longint'(coef_t'(data[63:32]));
					coef[F10] = longint'(coef_t'(data[31:0]));
				end
				REG_F11_F12: begin
					coef[F11] = longint'(coef_t'(data[63:32]));
					coef[F12] = longint'(coef_t'(data[31:0]));
				end
				REG_F20_F21: begin
					coef[F20] = longint'(coef_t'(data[63:32]));
					coef[F21] = longint'(coef_t'(data[31:0]));
				end
				REG_F22: coef[F22] = longint'(coef_t'(data[31:0]));
				REG_DIST_LIMIT: limit = data[LIM_W-1:0];
				default: ;
			endcase
		endfunction

		// epipolar line through the previous point, constant terms scaled by 16
		function void line_terms(logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py,
				output longint a, output longint b, output longint c);
			longint x;
			longint y;
			x = longint'(px);
			y = longint'(py);
			a = coef[F00] * x + coef[F01] * y + coef[F02] * 16;
			b = coef[F10] * x + coef[F11] * y + coef[F12] * 16;
			c = coef[F20] * x + coef[F21] * y + coef[F22] * 16;
		endfunction

		function logic [1:0] classify(pair_t p);
			longint a, b, c;
			logic signed [95:0] wa, wb, wc, wx, wy, num;
			logic [95:0] mag;
			logic [191:0] lhs, rhs, ma, mb;
			if (!p.ok) return CLS_DROP;
			line_terms(p.px, p.py, a, b, c);
			wa = 96'(a);
			wb = 96'(b);
			wc = 96'(c);
			wx = 96'(p.cx);
			wy = 96'(p.cy);
			num = wa * wx + wb * wy + wc * 96'sd16;
			mag = (num < 0) ? -num : num;
			lhs = {96'd0, mag} * {96'd0, mag};
			ma = (a < 0) ? 192'(-a) : 192'(a);
			mb = (b < 0) ? 192'(-b) : 192'(b);
			rhs = (ma * ma + mb * mb) * (192'(limit) * 192'(limit));
			return (lhs <= rhs) ? CLS_STATIC : CLS_MOVING;
		endfunction

		function void note_pair(pair_t p);
			point_t e;
			e.cls = classify(p);
			e.x = p.cx;
			e.y = p.cy;
			expected_points = {expected_points, e};
		endfunction

		function void check_point(logic [1:0] cls, logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y);
			point_t e;
			if (expected_points.size() == 0) begin
				errors++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("unexpected point: class %0d x %h y %h", cls, x, y);
				end
				return;
			end
			e = expected_points.pop_front();
			if (cls !== e.cls || x !== e.x || y !== e.y) begin
				errors++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("mismatch: expected class %0d x %h y %h, got class %0d x %h y %h",
						e.cls, e.x, e.y, cls, x, y);
				end
			end
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_addr  = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [FIELD_W-1:0]   prev_x    = '0;
	logic [FIELD_W-1:0]   prev_y    = '0;
	logic [FIELD_W-1:0]   cur_x     = '0;
	logic [FIELD_W-1:0]   cur_y     = '0;
	logic                 track_ok  = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           point_class;
	logic [FIELD_W-1:0]   out_x;
	logic [FIELD_W-1:0]   out_y;

	int idle_pct  = 0;
	int stall_pct = 0;
	int quiet     = 0;
	motion_ledger ledger = new();

	epipolar_motion_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.prev_x(prev_x),
		.prev_y(prev_y),
		.cur_x(cur_x),
		.cur_y(cur_y),
		.track_ok(track_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_class(point_class),
		.out_x(out_x),
		.out_y(out_y)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_point(point_class, out_x, out_y);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	task automatic set_pace(pace_t m);
		case (m)
			PACE_FULL: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			PACE_SEND_GAPS: begin
				idle_pct = 45;
				stall_pct = 0;
			end
			PACE_RECV_STALLS: begin
				idle_pct = 0;
				stall_pct = 45;
			end
			default: begin
				idle_pct = 35;
				stall_pct = 35;
			end
		endcase
	endtask

	// called just after a falling edge, returns just after one
	task automatic push_pair(pair_t p);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		prev_x <= p.px;
		prev_y <= p.py;
		cur_x <= p.cx;
		cur_y <= p.cy;
		track_ok <= p.ok;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ledger.note_pair(p);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= data;
		ledger.set_reg(idx, data);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic pair_t mk(logic [15:0] px, logic [15:0] py, logic [15:0] cx,
			logic [15:0] cy, logic ok);
		pair_t p;
		p.px = px;
		p.py = py;
		p.cx = cx;
		p.cy = cy;
		p.ok = ok;
		return p;
	endfunction

	// mostly points placed within twice the limit plus 8 of their epipolar line
	function automatic pair_t random_pair();
		pair_t p;
		longint a, b, c;
		logic signed [95:0] wa, wb, wc, wx, cy0;
		int span, d, r;
		p = mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
		r = $urandom_range(0, 99);
		if (r < 8) begin
			p.ok = 1'b0;
		end else if (r >= 20) begin
			ledger.line_terms(p.px, p.py, a, b, c);
			if (b != 0) begin
				wa = 96'(a);
				wb = 96'(b);
				wc = 96'(c);
				wx = 96'(p.cx);
				cy0 = -(wa * wx + wc * 96'sd16) / wb;
				span = 2 * int'(ledger.limit) + 8;
				d = int'($urandom_range(0, 2 * span)) - span;
				cy0 = cy0 + 96'(d);
				if (cy0 >= 0 && cy0 <= 65535)
					p.cy = cy0[15:0];
			end
		end
		return p;
	endfunction

	task automatic config_phase(int ph);
		logic [31:0] e[NCOEF];
		logic [CFG_W-1:0] lim_word;
		int k;
		foreach (e[i]) e[i] = '0;
		case ((ph + ph / 4) % 4)
			0: begin
				// pure sideways motion: the line is a row, distance is the row offset
				k = $urandom_range(1 << 20, 1 << 30);
				if ($urandom_range(0, 1)) k = -k;
				e[F12] = -k;
				e[F21] = k;
			end
			1: foreach (e[i]) e[i] = $urandom_range(0, 1 << 22) - (1 << 21);
			2: foreach (e[i]) e[i] = $urandom;
			default: begin
				foreach (e[i]) begin
					case ($urandom_range(0, 3))
						0: e[i] = 32'h8000_0000;
						1: e[i] = 32'h7FFF_FFFF;
						2: e[i] = '0;
						default: e[i] = $urandom;
					endcase
				end
			end
		endcase
		lim_word = {$urandom, $urandom};
		if (ph == 0)
			lim_word[LIM_W-1:0] = '0;
		else if (ph == 1)
			lim_word[LIM_W-1:0] = '1;
		else if ($urandom_range(0, 1))
			lim_word[LIM_W-1:0] = LIM_W'($urandom_range(0, 96));
		cfg_write(REG_F00_F01, {e[F00], e[F01]});
		cfg_write(REG_F02_F10, {e[F02], e[F10]});
		cfg_write(REG_F11_F12, {e[F11], e[F12]});
		cfg_write(REG_F20_F21, {e[F20], e[F21]});
		cfg_write(REG_F22, {$urandom, e[F22]});
		cfg_write(REG_DIST_LIMIT, lim_word);
		cfg_write((ph % 2) ? NO_REG_B : NO_REG_A, {$urandom, $urandom});
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_pace(PACE_FULL);

		// reset matrix is all zero: every valid point sits on a degenerate line
		push_pair(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
		push_pair(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		push_pair(mk(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0));
		push_pair(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));

		// sideways motion, default limit of two pixels: both sides of the boundary
		drain();
		cfg_write(REG_F11_F12, 64'h0000_0000_F000_0000);
		cfg_write(REG_F20_F21, 64'h0000_0000_1000_0000);
		push_pair(mk(16'h0640, 16'h1000, 16'h2000, 16'h1000, 1'b1));
		push_pair(mk(16'h0640, 16'h1000, 16'h0010, 16'h1020, 1'b1));
		push_pair(mk(16'h0640, 16'h1000, 16'h0010, 16'h1021, 1'b1));
		push_pair(mk(16'h0640, 16'h1000, 16'hFFF0, 16'h0FE0, 1'b1));
		push_pair(mk(16'h0640, 16'h1000, 16'hFFF0, 16'h0FDF, 1'b1));
		push_pair(mk(16'h0640, 16'h1000, 16'h0010, 16'h1021, 1'b0));

		// zero limit, upper register bits set
		drain();
		cfg_write(REG_DIST_LIMIT, 64'hFFFF_FFFF_FFFF_F000);
		push_pair(mk(16'h7777, 16'h2345, 16'h0101, 16'h2345, 1'b1));
		push_pair(mk(16'h7777, 16'h2345, 16'h0101, 16'h2346, 1'b1));

		// degenerate line with a nonzero numerator, even at the widest limit
		drain();
		cfg_write(REG_F11_F12, 64'h0);
		cfg_write(REG_F20_F21, 64'h0);
		cfg_write(REG_F22, 64'hDEAD_BEEF_0000_0001);
		cfg_write(REG_DIST_LIMIT, 64'hABCD_EF01_2345_6FFF);
		push_pair(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
		push_pair(mk(16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF, 1'b1));

		// degenerate line whose numerator vanishes only at column zero
		drain();
		cfg_write(REG_F22, 64'h0);
		cfg_write(REG_F20_F21, 64'h0001_0000_0000_0000);
		push_pair(mk(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1));
		push_pair(mk(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1));

		drain();
		cfg_write(NO_REG_A, '1);
		cfg_write(NO_REG_B, '1);
		push_pair(mk(16'h0000, 16'h4321, 16'h8765, 16'h0F0F, 1'b1));

		// most negative coefficients everywhere
		drain();
		cfg_write(REG_F00_F01, 64'h8000_0000_8000_0000);
		cfg_write(REG_F02_F10, 64'h8000_0000_8000_0000);
		cfg_write(REG_F11_F12, 64'h8000_0000_8000_0000);
		cfg_write(REG_F20_F21, 64'h8000_0000_8000_0000);
		cfg_write(REG_F22, 64'h0000_0000_8000_0000);
		push_pair(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		push_pair(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));

		// most positive coefficients everywhere
		drain();
		cfg_write(REG_F00_F01, 64'h7FFF_FFFF_7FFF_FFFF);
		cfg_write(REG_F02_F10, 64'h7FFF_FFFF_7FFF_FFFF);
		cfg_write(REG_F11_F12, 64'h7FFF_FFFF_7FFF_FFFF);
		cfg_write(REG_F20_F21, 64'h7FFF_FFFF_7FFF_FFFF);
		cfg_write(REG_F22, 64'hFFFF_FFFF_7FFF_FFFF);
		push_pair(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		push_pair(mk(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			config_phase(ph);
			set_pace(pace_t'(ph % 4));
			repeat (ITEMS_PER_PHASE) push_pair(random_pair());
		end
		drain();

		if (ledger.errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule

FILE: filelist.f
src/emc_pkg.sv
src/emc_line.sv
src/emc_square.sv
src/emc_test.sv
src/epipolar_motion_classifier.sv
bench/tb_top.sv
